// ----- src/bpe_pkg.sv -----
package bpe_pkg;

    // Coefficient store geometry
    localparam int MAX_DEGREE  = 4;
    localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DEGREE + 1);
    localparam int TRI_W       = 2 * CNT_W + 2;

    // Field widths
    localparam int POW_W   = 3;
    localparam int DEG_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = ACC_W + DATA_W;
    localparam int Q_W     = PROD_W - FRAC_W;

    localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W - 1){1'b0}}};

    // Command opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Register port
    localparam int                 PADDR_W           = 2;
    localparam int                 PDATA_W           = 32;
    localparam logic [PADDR_W-1:0] REG_POLY_DEGREE   = 2'd0;
    localparam logic [DEG_W-1:0]   POLY_DEGREE_RESET = 3'd4;

    // Microprogram
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] STEP_LOAD   = 4'd1;
    localparam logic [PC_W-1:0] STEP_TESTX  = 4'd2;
    localparam logic [PC_W-1:0] STEP_MLO_X  = 4'd3;
    localparam logic [PC_W-1:0] STEP_MHI_X  = 4'd4;
    localparam logic [PC_W-1:0] STEP_SUM_X  = 4'd5;
    localparam logic [PC_W-1:0] STEP_SAT_X  = 4'd6;
    localparam logic [PC_W-1:0] STEP_TESTY  = 4'd7;
    localparam logic [PC_W-1:0] STEP_MLO_Y  = 4'd8;
    localparam logic [PC_W-1:0] STEP_MHI_Y  = 4'd9;
    localparam logic [PC_W-1:0] STEP_SUM_Y  = 4'd10;
    localparam logic [PC_W-1:0] STEP_SAT_Y  = 4'd11;
    localparam logic [PC_W-1:0] STEP_ACCUM  = 4'd12;
    localparam logic [PC_W-1:0] STEP_EMIT   = 4'd13;
    localparam logic [PC_W-1:0] PROG_LAST   = STEP_EMIT;

    typedef enum logic [3:0] {
        DP_NOP     = 4'd0,
        DP_IDLE    = 4'd1,
        DP_LOAD    = 4'd2,
        DP_MUL_LO  = 4'd3,
        DP_MUL_HI  = 4'd4,
        DP_SUM     = 4'd5,
        DP_SAT     = 4'd6,
        DP_ACCUM   = 4'd7,
        DP_EMIT    = 4'd8
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NO_EVAL    = 3'd2,
        COND_KX_ZERO    = 3'd3,
        COND_KY_ZERO    = 3'd4,
        COND_MORE_TERMS = 3'd5,
        COND_OUT_BUSY   = 3'd6
    } cond_t;

    typedef enum logic [2:0] {
        CNT_HOLD      = 3'd0,
        CNT_CLEAR     = 3'd1,
        CNT_LOAD_K    = 3'd2,
        CNT_DEC_X     = 3'd3,
        CNT_DEC_Y     = 3'd4,
        CNT_NEXT_TERM = 3'd5
    } cnt_t;

    typedef struct packed {
        dp_op_t          op;
        logic            sel_y;
        cond_t           cond;
        cnt_t            cnt;
        logic [PC_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_y;
        logic   start;
    } dp_ctl_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
    } store_ctl_t;

    // Position of the pair (i, j) in the triangular store, rows of constant i.
    function automatic logic [ADDR_W-1:0] tri_index(input logic [CNT_W-1:0] i,
                                                    input logic [CNT_W-1:0] j);
        logic [TRI_W-1:0] iw;
        logic [TRI_W-1:0] jw;
        logic [TRI_W-1:0] base;
        iw   = TRI_W'(i);
        jw   = TRI_W'(j);
        base = iw * TRI_W'(MAX_DEGREE + 1) - ((iw * (iw - TRI_W'(1))) >> 1) + jw;
        return ADDR_W'(base);
    endfunction

    // Control store: one word per step.
    function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
        ucw_t w;
        w = '{op: DP_NOP, sel_y: 1'b0, cond: COND_ALWAYS, cnt: CNT_HOLD, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:  w = '{DP_IDLE,   1'b0, COND_NO_EVAL,    CNT_CLEAR,     STEP_IDLE};
            STEP_LOAD:  w = '{DP_LOAD,   1'b0, COND_NEVER,      CNT_LOAD_K,    STEP_IDLE};
            STEP_TESTX: w = '{DP_NOP,    1'b0, COND_KX_ZERO,    CNT_HOLD,      STEP_TESTY};
            STEP_MLO_X: w = '{DP_MUL_LO, 1'b0, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_MHI_X: w = '{DP_MUL_HI, 1'b0, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_SUM_X: w = '{DP_SUM,    1'b0, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_SAT_X: w = '{DP_SAT,    1'b0, COND_ALWAYS,     CNT_DEC_X,     STEP_TESTX};
            STEP_TESTY: w = '{DP_NOP,    1'b1, COND_KY_ZERO,    CNT_HOLD,      STEP_ACCUM};
            STEP_MLO_Y: w = '{DP_MUL_LO, 1'b1, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_MHI_Y: w = '{DP_MUL_HI, 1'b1, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_SUM_Y: w = '{DP_SUM,    1'b1, COND_NEVER,      CNT_HOLD,      STEP_IDLE};
            STEP_SAT_Y: w = '{DP_SAT,    1'b1, COND_ALWAYS,     CNT_DEC_Y,     STEP_TESTY};
            STEP_ACCUM: w = '{DP_ACCUM,  1'b0, COND_MORE_TERMS, CNT_NEXT_TERM, STEP_LOAD};
            STEP_EMIT:  w = '{DP_EMIT,   1'b0, COND_OUT_BUSY,   CNT_HOLD,      STEP_EMIT};
            default:    w = '{DP_NOP,    1'b0, COND_ALWAYS,     CNT_HOLD,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/bpe_ifs.sv -----
interface bpe_cmd_if;
    import bpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [POW_W-1:0]         power_of_x;
    logic [POW_W-1:0]         power_of_y;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;

    modport source (
        output valid, opcode, power_of_x, power_of_y, coeff_value, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, power_of_x, power_of_y, coeff_value, point_x, point_y,
        output ready
    );
endinterface

interface bpe_res_if;
    import bpe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] poly_value;
    logic                    overflowed;

    modport source (
        output valid, poly_value, overflowed,
        input  ready
    );

    modport sink (
        input  valid, poly_value, overflowed,
        output ready
    );
endinterface

// ----- src/bpe_coeff_store.sv -----
module bpe_coeff_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  bpe_pkg::store_ctl_t        ctl,
    input  logic [bpe_pkg::DATA_W-1:0] wr_data,
    output logic [bpe_pkg::DATA_W-1:0] rd_data
);
    import bpe_pkg::*;

    logic [DATA_W-1:0] coeff_reg [STORE_DEPTH];

    // Fifteen flip-flop entries; reset and a degree change zero them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < STORE_DEPTH; e++)
            begin
                coeff_reg[e] <= '0;
            end
        end
        else if (clear)
        begin
            for (int e = 0; e < STORE_DEPTH; e++)
            begin
                coeff_reg[e] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            coeff_reg[ctl.wr_addr] <= wr_data;
        end
    end

    assign rd_data = coeff_reg[ctl.rd_addr];

endmodule

// ----- src/bpe_mac.sv -----
module bpe_mac (
    input  logic                       clk,
    input  bpe_pkg::dp_ctl_t           ctl,
    input  logic [bpe_pkg::DATA_W-1:0] point_x,
    input  logic [bpe_pkg::DATA_W-1:0] point_y,
    input  logic [bpe_pkg::DATA_W-1:0] coeff,
    output logic [bpe_pkg::ACC_W-1:0]  acc,
    output logic                       ovf
);
    import bpe_pkg::*;

    logic [DATA_W-1:0]   xmag_reg, xmag_next;
    logic [DATA_W-1:0]   ymag_reg, ymag_next;
    logic                xneg_reg, xneg_next;
    logic                yneg_reg, yneg_next;
    logic [ACC_W-1:0]    tval_reg, tval_next;
    logic [ACC_W-1:0]    tmag_reg, tmag_next;
    logic                tneg_reg, tneg_next;
    logic [2*DATA_W-1:0] plo_reg, plo_next;
    logic [2*DATA_W-1:0] phi_reg, phi_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                ovf_reg, ovf_next;

    logic [DATA_W-1:0]   bmag;
    logic                bneg;
    logic                rneg;
    logic [DATA_W-1:0]   mul_a;
    logic [2*DATA_W-1:0] mul_p;
    logic [PROD_W-1:0]   sum_full;
    logic [ACC_W-1:0]    qlo;
    logic                qhi_nz;
    logic [DATA_W-1:0]   cmag;
    logic [ACC_W-1:0]    add_s;
    logic                add_ovf;

    assign bmag  = ctl.sel_y ? ymag_reg : xmag_reg;
    assign bneg  = ctl.sel_y ? yneg_reg : xneg_reg;
    assign rneg  = tneg_reg ^ bneg;

    // One 32x32 multiplier serves both halves of the running term magnitude.
    assign mul_a = (ctl.op == DP_MUL_HI) ? tmag_reg[ACC_W-1:DATA_W] : tmag_reg[DATA_W-1:0];
    assign mul_p = mul_a * bmag;

    assign sum_full = {{DATA_W{1'b0}}, plo_reg} + {phi_reg, {DATA_W{1'b0}}};
    assign qlo      = q_reg[ACC_W-1:0];
    assign qhi_nz   = |q_reg[Q_W-1:ACC_W];

    assign cmag    = coeff[DATA_W-1] ? (~coeff + DATA_W'(1)) : coeff;
    assign add_s   = acc_reg + tval_reg;
    assign add_ovf = (acc_reg[ACC_W-1] == tval_reg[ACC_W-1]) &&
                     (add_s[ACC_W-1] != acc_reg[ACC_W-1]);

    always_comb
    begin
        xmag_next = xmag_reg;
        ymag_next = ymag_reg;
        xneg_next = xneg_reg;
        yneg_next = yneg_reg;
        tval_next = tval_reg;
        tmag_next = tmag_reg;
        tneg_next = tneg_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;

        if (ctl.start)
        begin
            xneg_next = point_x[DATA_W-1];
            yneg_next = point_y[DATA_W-1];
            xmag_next = point_x[DATA_W-1] ? (~point_x + DATA_W'(1)) : point_x;
            ymag_next = point_y[DATA_W-1] ? (~point_y + DATA_W'(1)) : point_y;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end

        case (ctl.op)
            DP_LOAD:
            begin
                tval_next = {{DATA_W{coeff[DATA_W-1]}}, coeff};
                tmag_next = {{DATA_W{1'b0}}, cmag};
                tneg_next = coeff[DATA_W-1];
            end
            DP_MUL_LO:
            begin
                plo_next = mul_p;
            end
            DP_MUL_HI:
            begin
                phi_next = mul_p;
            end
            DP_SUM:
            begin
                q_next = sum_full[PROD_W-1:FRAC_W];
            end
            DP_SAT:
            begin
                // Sign and magnitude are kept alongside the value so the next
                // multiply starts without a negation.
                if (rneg)
                begin
                    if (qhi_nz || (qlo > SAT_NEG))
                    begin
                        tval_next = SAT_NEG;
                        tmag_next = SAT_NEG;
                        tneg_next = 1'b1;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        tval_next = ~qlo + ACC_W'(1);
                        tmag_next = qlo;
                        tneg_next = |qlo;
                    end
                end
                else
                begin
                    if (qhi_nz || qlo[ACC_W-1])
                    begin
                        tval_next = SAT_POS;
                        tmag_next = SAT_POS;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        tval_next = qlo;
                        tmag_next = qlo;
                    end
                    tneg_next = 1'b0;
                end
            end
            DP_ACCUM:
            begin
                if (add_ovf)
                begin
                    acc_next = acc_reg[ACC_W-1] ? SAT_NEG : SAT_POS;
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = add_s;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        xmag_reg <= xmag_next;
        ymag_reg <= ymag_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        tval_reg <= tval_next;
        tmag_reg <= tmag_next;
        tneg_reg <= tneg_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        ovf_reg  <= ovf_next;
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

// ----- src/bpe_ctrl.sv -----
module bpe_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  logic                      cmd_opcode,
    input  logic [bpe_pkg::POW_W-1:0] power_of_x,
    input  logic [bpe_pkg::POW_W-1:0] power_of_y,
    input  logic [bpe_pkg::CNT_W-1:0] degree,
    input  logic                      out_busy,
    output logic                      cmd_ready,
    output bpe_pkg::dp_ctl_t          dp_ctl,
    output bpe_pkg::store_ctl_t       store_ctl
);
    import bpe_pkg::*;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] kx_reg, kx_next;
    logic [CNT_W-1:0] ky_reg, ky_next;

    ucw_t             uw;
    logic             idle;
    logic             eval_acc;
    logic             wr_acc;
    logic             jump;
    logic [CNT_W:0]   ij_sum;
    logic [POW_W:0]   pw_sum;

    assign uw       = ucode_rom(pc_reg);
    assign idle     = (pc_reg == STEP_IDLE);
    assign cmd_ready = idle;
    assign eval_acc = idle && cmd_valid && (cmd_opcode == OP_EVAL);
    assign wr_acc   = idle && cmd_valid && (cmd_opcode == OP_WRITE);
    assign ij_sum   = {1'b0, i_reg} + {1'b0, j_reg};
    assign pw_sum   = {1'b0, power_of_x} + {1'b0, power_of_y};

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:     jump = 1'b1;
            COND_NO_EVAL:    jump = !eval_acc;
            COND_KX_ZERO:    jump = (kx_reg == '0);
            COND_KY_ZERO:    jump = (ky_reg == '0);
            COND_MORE_TERMS: jump = (i_reg != degree);
            COND_OUT_BUSY:   jump = out_busy;
            default:         jump = 1'b0;
        endcase

        if (jump)
        begin
            pc_next = uw.target;
        end
        else if (pc_reg == PROG_LAST)
        begin
            pc_next = STEP_IDLE;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // Term walk: j runs along a row until i + j reaches the degree, then i steps.
    always_comb
    begin
        i_next  = i_reg;
        j_next  = j_reg;
        kx_next = kx_reg;
        ky_next = ky_reg;
        case (uw.cnt)
            CNT_CLEAR:
            begin
                i_next = '0;
                j_next = '0;
            end
            CNT_LOAD_K:
            begin
                kx_next = i_reg;
                ky_next = j_reg;
            end
            CNT_DEC_X:
            begin
                kx_next = kx_reg - CNT_W'(1);
            end
            CNT_DEC_Y:
            begin
                ky_next = ky_reg - CNT_W'(1);
            end
            CNT_NEXT_TERM:
            begin
                if (ij_sum < {1'b0, degree})
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                else if (i_reg != degree)
                begin
                    i_next = i_reg + CNT_W'(1);
                    j_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
            i_reg  <= '0;
            j_reg  <= '0;
            kx_reg <= '0;
            ky_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            i_reg  <= i_next;
            j_reg  <= j_next;
            kx_reg <= kx_next;
            ky_reg <= ky_next;
        end
    end

    assign dp_ctl.op    = uw.op;
    assign dp_ctl.sel_y = uw.sel_y;
    assign dp_ctl.start = eval_acc;

    assign store_ctl.wr_en   = wr_acc && (pw_sum <= degree);
    assign store_ctl.wr_addr = tri_index(CNT_W'(power_of_x), CNT_W'(power_of_y));
    assign store_ctl.rd_addr = tri_index(i_reg, j_reg);

    a_eval_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        eval_acc |=> (pc_reg == STEP_LOAD) && (i_reg == '0) && (j_reg == '0))
        else $error("evaluation did not start at the first term");

    a_term_in_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != STEP_IDLE) |-> (ij_sum <= {1'b0, degree}))
        else $error("term walk left the triangle");

    a_store_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctl.wr_en |-> (32'(store_ctl.wr_addr) < STORE_DEPTH))
        else $error("store write beyond the triangle");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PROG_LAST)
        else $error("step counter outside the program");

endmodule

// ----- src/bivariate_polynomial_evaluator_unit.sv -----
// An evaluate item at degree d walks T = (d+1)(d+2)/2 terms holding S = d(d+1)(d+2)/3
// multiplies; no new item is taken until the sequencer is back in its idle step, and an
// evaluation waits in its emit step while the output register is still full.
// The run time is set by the single shared 32x32 multiplier: each Q48.16 by Q16.16 multiply
// takes five steps, four on the datapath and one loop test. Reset (rst_n low, asynchronous)
// sets poly_degree to 4, zeroes all fifteen coefficients and empties the output register.
module bivariate_polynomial_evaluator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    bpe_cmd_if.sink                     cmd,
    bpe_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpe_pkg::PADDR_W-1:0] paddr,
    input  logic [bpe_pkg::PDATA_W-1:0] pwdata,
    output logic [bpe_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bpe_pkg::*;

    // Configuration register. Writing the degree also wipes the coefficient
    // store, so a new polynomial always starts from all-zero coefficients.
    logic [DEG_W-1:0]  poly_degree_reg, poly_degree_next;
    logic              cfg_wr;
    logic              degree_wr;
    logic [CNT_W-1:0]  eff_degree;

    // Output register: holds a finished result until the sink takes it, while
    // the sequencer is already free to take the next item.
    logic              res_valid_reg, res_valid_next;
    logic [ACC_W-1:0]  poly_value_reg, poly_value_next;
    logic              overflowed_reg, overflowed_next;
    logic              out_busy;
    logic              emit;

    dp_ctl_t           dp_ctl;
    store_ctl_t        store_ctl;
    logic [DATA_W-1:0] coeff_rd;
    logic [ACC_W-1:0]  acc;
    logic              ovf;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign degree_wr = cfg_wr && (paddr == REG_POLY_DEGREE);

    assign prdata = (paddr == REG_POLY_DEGREE) ? PDATA_W'(poly_degree_reg) : '0;

    always_comb
    begin
        poly_degree_next = poly_degree_reg;
        if (degree_wr)
        begin
            poly_degree_next = pwdata[DEG_W-1:0];
        end
    end

    // A degree above what the store holds behaves as the largest one.
    always_comb
    begin
        if (32'(poly_degree_reg) > MAX_DEGREE)
        begin
            eff_degree = CNT_W'(MAX_DEGREE);
        end
        else
        begin
            eff_degree = CNT_W'(poly_degree_reg);
        end
    end

    assign out_busy = res_valid_reg && !res.ready;
    assign emit     = (dp_ctl.op == DP_EMIT) && !out_busy;

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        poly_value_next = poly_value_reg;
        overflowed_next = overflowed_reg;
        if (emit)
        begin
            res_valid_next  = 1'b1;
            poly_value_next = acc;
            overflowed_next = ovf;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= POLY_DEGREE_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            poly_degree_reg <= poly_degree_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poly_value_reg <= poly_value_next;
        overflowed_reg <= overflowed_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.poly_value = poly_value_reg;
    assign res.overflowed = overflowed_reg;

    // The sequencer steps through its control program, one step per cycle while not waiting
    // for an item or a free output, and loops over the powers of x and y, then the triangle's terms.
    bpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .power_of_x (cmd.power_of_x),
        .power_of_y (cmd.power_of_y),
        .degree     (eff_degree),
        .out_busy   (out_busy),
        .cmd_ready  (cmd.ready),
        .dp_ctl     (dp_ctl),
        .store_ctl  (store_ctl)
    );

    bpe_coeff_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (degree_wr),
        .ctl     (store_ctl),
        .wr_data (cmd.coeff_value),
        .rd_data (coeff_rd)
    );

    // Multiply-accumulate datapath: every product is truncated to 16 fraction
    // bits and clamped to 64 bits before the next multiply or the sum.
    bpe_mac u_mac (
        .clk     (clk),
        .ctl     (dp_ctl),
        .point_x (cmd.point_x),
        .point_y (cmd.point_y),
        .coeff   (coeff_rd),
        .acc     (acc),
        .ovf     (ovf)
    );

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> res_valid_reg)
        else $error("finished result not placed in the output register");

endmodule

// ----- test/tb_bivariate_polynomial_evaluator_unit.sv -----
`timescale 1ns / 100ps

module tb_bivariate_polynomial_evaluator_unit;
    import bpe_pkg::*;

    // Run shape. The settle time after the last result is taken is set to outlast an
    // evaluation at the full degree.
    localparam int RANDOM_ITEMS   = 1028;
    localparam int N_PHASES       = 8;
    localparam int N_DIRECTED     = 22;
    localparam int MAX_GAP        = 8;
    localparam int LONG_HOLD      = 2000;
    localparam int LATENCY_CYCLES = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int PRINT_LIMIT    = 100;
    localparam int TIMEOUT_NS     = 5_000_000;

    // One command item as it travels on the command channel.
    typedef struct packed {
        logic              op;
        logic [POW_W-1:0]  px;
        logic [POW_W-1:0]  py;
        logic [DATA_W-1:0] coeff;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } poly_cmd_t;

    // One result item: the saturated sum and its overflow flag.
    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             sat;
    } poly_sum_t;

    // A row of the directed table. When fixed_sum is set, the expected result is
    // the one typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        poly_cmd_t cmd;
        logic      fixed_sum;
        poly_sum_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bpe_cmd_if cmd_bus ();
    bpe_res_if res_bus ();

    // Shadow copy of the block's configuration and coefficient store.
    logic [DEG_W-1:0]  degree_shadow;
    logic [DATA_W-1:0] coeff_shadow [0:MAX_DEGREE][0:MAX_DEGREE];

    // Sums still owed by the block, oldest first.
    poly_sum_t pending_sums [$];

    // Set by the stimulus side to ask the result side for one long hold-off.
    bit long_hold_req = 1'b0;

    int err_count      = 0;
    int n_eval_items   = 0;
    int n_sums_checked = 0;
    int n_sat_sums     = 0;
    int n_coeff_stored = 0;
    int n_coeff_dropped = 0;

    bivariate_polynomial_evaluator_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus.sink),
        .res     (res_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_bivariate_polynomial_evaluator_unit: done, errors");
        $finish;
    end

    // Every mismatch goes through here. Printing is capped so a badly broken
    // block does not flood the log, but every mismatch is counted.
    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // A degree register above the store's limit behaves as the limit itself.
    function automatic int eff_degree();
        return (int'(degree_shadow) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_shadow);
    endfunction

    task automatic clear_shadow_store();
        for (int i = 0; i <= MAX_DEGREE; i++)
        begin
            for (int j = 0; j <= MAX_DEGREE; j++)
            begin
                coeff_shadow[i][j] = '0;
            end
        end
    endtask

    // Q48.16 times Q16.16: multiply magnitudes, drop 16 fraction bits (which
    // truncates toward zero), put the sign back and clamp to 64 bits.
    function automatic logic [ACC_W-1:0] q_mul(input logic [ACC_W-1:0] a,
                                               input logic [DATA_W-1:0] b,
                                               output logic sat);
        logic              neg;
        logic [ACC_W-1:0]  mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [PROD_W-1:0] prod;
        logic [Q_W-1:0]    q;
        neg   = a[ACC_W-1] ^ b[DATA_W-1];
        mag_a = a[ACC_W-1] ? (~a + 1'b1) : a;
        mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
        prod  = PROD_W'(mag_a) * PROD_W'(mag_b);
        q     = prod[PROD_W-1:FRAC_W];
        sat   = 1'b0;
        if (neg)
        begin
            if (q > Q_W'(SAT_NEG))
            begin
                sat = 1'b1;
                return SAT_NEG;
            end
            return ~q[ACC_W-1:0] + 1'b1;
        end
        if (q > Q_W'(SAT_POS))
        begin
            sat = 1'b1;
            return SAT_POS;
        end
        return q[ACC_W-1:0];
    endfunction

    // Two's complement add that clamps when both operands share a sign and the
    // sum does not.
    function automatic logic [ACC_W-1:0] q_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b,
                                               output logic sat);
        logic [ACC_W-1:0] s;
        s   = a + b;
        sat = 1'b0;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
        begin
            sat = 1'b1;
            return a[ACC_W-1] ? SAT_NEG : SAT_POS;
        end
        return s;
    endfunction

    // Value of the stored polynomial at (x, y). Each term starts from its
    // coefficient, is multiplied by x i times and then by y j times, and the
    // terms are summed in row order, i outer and j inner.
    function automatic poly_sum_t eval_poly(input logic [DATA_W-1:0] x,
                                            input logic [DATA_W-1:0] y);
        poly_sum_t        r;
        logic [ACC_W-1:0] term;
        logic             sat;
        int               deg;
        deg     = eff_degree();
        r.value = '0;
        r.sat   = 1'b0;
        for (int i = 0; i <= deg; i++)
        begin
            for (int j = 0; i + j <= deg; j++)
            begin
                term = {{(ACC_W - DATA_W){coeff_shadow[i][j][DATA_W-1]}}, coeff_shadow[i][j]};
                for (int k = 0; k < i; k++)
                begin
                    term  = q_mul(term, x, sat);
                    r.sat = r.sat | sat;
                end
                for (int k = 0; k < j; k++)
                begin
                    term  = q_mul(term, y, sat);
                    r.sat = r.sat | sat;
                end
                r.value = q_add(r.value, term, sat);
                r.sat   = r.sat | sat;
            end
        end
        return r;
    endfunction

    // Mix of small magnitudes (so that high powers do not always clamp), the
    // corner values of Q16.16, and fully random words.
    function automatic logic [DATA_W-1:0] pick_q16();
        logic [DATA_W-1:0] v;
        int                roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            v = DATA_W'($urandom_range(0, 32'h0003_FFFF));
            if ($urandom_range(0, 1) == 1)
            begin
                v = ~v + 1'b1;
            end
        end
        else if (roll < 6)
        begin
            case ($urandom_range(0, 7))
                0:       v = 32'h0000_0000;
                1:       v = 32'h0000_0001;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h0001_0000;
                4:       v = 32'hFFFF_0000;
                5:       v = 32'h7FFF_FFFF;
                6:       v = 32'h8000_0000;
                default: v = 32'h0000_8000;
            endcase
        end
        else
        begin
            v = $urandom();
        end
        return v;
    endfunction

    // Offers one item after the given gap and waits until the block takes it.
    // The shadow state is updated at the edge where the item is accepted. Valid
    // is left high on return so that a following item with no gap goes out
    // back to back.
    task automatic send_cmd(input poly_cmd_t c, input int gap, input logic fixed_sum,
                            input poly_sum_t want);
        logic [POW_W:0] pow_sum;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.opcode      <= c.op;
        cmd_bus.power_of_x  <= c.px;
        cmd_bus.power_of_y  <= c.py;
        cmd_bus.coeff_value <= c.coeff;
        cmd_bus.point_x     <= c.x;
        cmd_bus.point_y     <= c.y;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);

        pow_sum = {1'b0, c.px} + {1'b0, c.py};
        if (c.op == OP_EVAL)
        begin
            pending_sums.push_back(fixed_sum ? want : eval_poly(c.x, c.y));
            n_eval_items++;
        end
        else if (int'(pow_sum) <= eff_degree())
        begin
            coeff_shadow[c.px][c.py] = c.coeff;
            n_coeff_stored++;
        end
        else
        begin
            // A write beyond the current degree is dropped and gives no result.
            n_coeff_dropped++;
        end
    endtask

    // Stops offering items and waits until every owed sum has come back, then
    // lets the block settle. The wait is bounded so the end checks still run.
    task automatic drain_results();
        int waited;
        waited = 0;
        cmd_bus.valid <= 1'b0;
        while (pending_sums.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    // Register write through the configuration port: setup cycle, then access
    // cycle. Changing the degree also wipes the coefficient store. The upper
    // data bits carry junk now and then; only the low bits hold the degree.
    task automatic write_degree(input logic [DEG_W-1:0] deg);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POLY_DEGREE;
        if ($urandom_range(0, 1) == 1)
        begin
            pwdata <= {(PDATA_W - DEG_W)'($urandom()), deg};
        end
        else
        begin
            pwdata <= PDATA_W'(deg);
        end
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        degree_shadow = deg;
        clear_shadow_store();
    endtask

    // Result side: waits a random number of cycles before each item, runs
    // stretches with no waiting at all, and takes one long hold-off when the
    // stimulus side asks for it so that the block backs up into its input.
    initial
    begin : result_sink
        int        stall;
        int        taken;
        bit        burst;
        poly_sum_t got;
        poly_sum_t want;
        taken = 0;
        burst = 1'b0;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
            begin
                stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_bus.valid !== 1'b1);

            got.value = res_bus.poly_value;
            got.sat   = res_bus.overflowed;
            if (pending_sums.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value=%h overflowed=%b",
                                          got.value, got.sat));
            end
            else
            begin
                want = pending_sums.pop_front();
                if (got.value !== want.value || got.sat !== want.sat)
                begin
                    report_mismatch($sformatf(
                        "value got %h want %h, overflowed got %b want %b",
                        got.value, want.value, got.sat, want.sat));
                end
                n_sums_checked++;
                if (want.sat)
                begin
                    n_sat_sums++;
                end
            end

            taken++;
            if (taken % 40 == 0)
            begin
                burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t         directed_rows [N_DIRECTED];
        logic [DEG_W-1:0] phase_degrees [N_PHASES];
        poly_cmd_t        c;
        poly_sum_t        no_sum;
        int               per_phase;
        int               counted;
        int               eff;
        int               roll;
        bit               send_burst;
        bit               hold_done;

        // Known levels on every input from time zero.
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.opcode      <= OP_WRITE;
        cmd_bus.power_of_x  <= '0;
        cmd_bus.power_of_y  <= '0;
        cmd_bus.coeff_value <= '0;
        cmd_bus.point_x     <= '0;
        cmd_bus.point_y     <= '0;

        degree_shadow = POLY_DEGREE_RESET;
        clear_shadow_store();
        no_sum     = '0;
        send_burst = 1'b0;
        hold_done  = 1'b0;

        // Directed part, at the reset degree. Sums typed in here follow from a
        // nearly empty store: an empty store gives zero, and with x = y = 0 only
        // the constant coefficient survives, sign extended to 64 bits.
        directed_rows = '{
            // evaluation of the freshly cleared store at extreme coordinates
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
              1'b1, '{64'h0000_0000_0000_0000, 1'b0}},
            '{'{OP_WRITE, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b1, '{64'h0000_0000_7FFF_FFFF, 1'b0}},
            '{'{OP_WRITE, 3'd0, 3'd0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b1, '{64'hFFFF_FFFF_8000_0000, 1'b0}},
            // highest powers of x, of y, and a mixed term of value one
            '{'{OP_WRITE, 3'd4, 3'd0, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd0, 3'd4, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd2, 3'd2, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            // writes past the degree, which must leave the store alone
            '{'{OP_WRITE, 3'd5, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd4, 3'd1, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            // clamping products and sums at both ends, unit and half points
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0000_8000, 32'hFFFF_FFFF},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd1, 3'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd3, 3'd1, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd1, 3'd1, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            // tiny negative x against tiny y: truncation toward zero
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0002_0000, 32'hFFFE_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_WRITE, 3'd0, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
              1'b0, '{64'h0, 1'b0}},
            '{'{OP_EVAL,  3'd0, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
              1'b0, '{64'h0, 1'b0}}
        };

        // Degrees visited by the random phases: both extremes of the register,
        // values above the store's limit, and the full degree again at the end.
        phase_degrees = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_cmd(directed_rows[r].cmd, $urandom_range(0, MAX_GAP),
                     directed_rows[r].fixed_sum, directed_rows[r].want);
        end
        drain_results();

        // Random phases. Each starts with a degree write on an idle block, which
        // also clears the store. Dropped writes count toward the phase as well.
        per_phase = RANDOM_ITEMS / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_degree(phase_degrees[ph]);
            @(posedge clk);
            eff     = eff_degree();
            counted = 0;
            while (counted < per_phase)
            begin
                if (counted % 32 == 0)
                begin
                    send_burst = ($urandom_range(0, 3) == 0);
                end
                // Once, early in a phase at the full effective degree, hold the result side
                // off for a long time while items keep coming.
                if (ph == 4 && counted == 12 && !hold_done)
                begin
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end

                c.coeff = pick_q16();
                c.x     = pick_q16();
                c.y     = pick_q16();
                roll    = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    c.op = OP_EVAL;
                    c.px = POW_W'($urandom_range(0, 7));
                    c.py = POW_W'($urandom_range(0, 7));
                end
                else if (roll < 88)
                begin
                    c.op = OP_WRITE;
                    c.px = POW_W'($urandom_range(0, eff));
                    c.py = POW_W'($urandom_range(0, eff - int'(c.px)));
                end
                else
                begin
                    c.op = OP_WRITE;
                    c.px = POW_W'($urandom_range(0, 7));
                    c.py = POW_W'($urandom_range(0, 7));
                end

                counted++;
                send_cmd(c, send_burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, no_sum);
            end
            drain_results();
        end

        if (pending_sums.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_sums.size()));
        end

        $display("Covered %0d evaluations (%0d saturated) and %0d stored / %0d dropped",
                 n_sums_checked, n_sat_sums, n_coeff_stored, n_coeff_dropped);
        $display("coefficient writes over %0d degree settings, with one long output stall.",
                 N_PHASES + 1);
        if (err_count == 0)
        begin
            $display("tb_bivariate_polynomial_evaluator_unit: done, clean");
        end
        else
        begin
            $display("tb_bivariate_polynomial_evaluator_unit: done, errors");
        end
        $finish;
    end

endmodule
